### design/lofi_pkg.sv
`timescale 1ns / 1ps
package lofi_pkg;

  localparam int MaxLinesDef   = 1024;
  localparam int OffsetBitsDef = 24;
  localparam int FieldW        = 24;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_LOCATE = 2'd1,
    MODE_RANGE  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // which answer the datapath builds when the controller loads the result
  typedef enum logic [2:0] {
    RES_FULL   = 3'd0,
    RES_BAD    = 3'd1,
    RES_APPEND = 3'd2,
    RES_LOCATE = 3'd3,
    RES_RANGE  = 3'd4,
    RES_CLEAR  = 3'd5
  } res_kind_t;

  typedef struct packed {
    mode_t              mode;
    logic [FieldW-1:0]  amount;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [FieldW-1:0]  first_value;
    logic [FieldW-1:0]  second_value;
  } resp_t;

  typedef struct packed {
    logic      capture;
    logic      mem_rd;
    logic      app_wr;
    logic      loc_skip;
    logic      loc_cmp;
    logic      rng_acc;
    logic      rng_second;
    logic      clear;
    logic      res_load;
    res_kind_t res_kind;
  } lofi_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full_err;
    logic  loc_err;
    logic  rng_err;
    logic  app_more;
    logic  probe_ok;
    logic  loc_more;
    logic  rng_more;
    logic  pass2;
    logic  out_free;
  } lofi_stat_t;

endpackage

### design/lofi_ram.sv
`timescale 1ns / 1ps
module lofi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lofi_datapath.sv
`timescale 1ns / 1ps
module lofi_datapath import lofi_pkg::*; #(
  parameter int MAX_LINES   = MaxLinesDef,
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       in_data,
  input  lofi_cmd_t  cmd,
  output lofi_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output resp_t      out_data
);

  localparam int AW      = $clog2(MAX_LINES + 1);
  localparam int LW      = AW;
  localparam int KW      = AW + 1;
  localparam int OB      = OFFSET_BITS;
  localparam int VW      = ((OB > FieldW) ? OB : FieldW) + 1;
  localparam int TopStep = 1 << (AW - 1);

  localparam logic [KW-1:0] KMax    = KW'(MAX_LINES);
  localparam logic [LW-1:0] StepTop = LW'(TopStep);
  localparam logic [VW-1:0] OMask   = {{(VW - OB){1'b0}}, {OB{1'b1}}};

  mode_t          mode;
  logic [FieldW-1:0] amount;
  logic [LW-1:0]  line_total;
  logic [OB-1:0]  byte_total;
  logic [KW-1:0]  k;
  logic [LW-1:0]  pos;
  logic [LW-1:0]  step;
  logic [OB-1:0]  sum;
  logic [OB-1:0]  start;
  logic           pass2;

  logic [OB-1:0]  rdata;
  logic [KW-1:0]  lowbit, k_up, k_down, probe;
  logic           entry_live, fits;
  logic [OB-1:0]  amount_ob, app_new;
  logic [VW-1:0]  amt_v, byte_v, line_v, sum_v, rdata_v;
  logic [AW-1:0]  raddr;
  resp_t          res;

  assign amt_v     = VW'(amount);
  assign byte_v    = VW'(byte_total);
  assign line_v    = VW'(line_total);
  assign sum_v     = VW'(sum);
  assign rdata_v   = VW'(rdata);
  assign amount_ob = amt_v[OB-1:0];

  assign lowbit = k & (~k + {{(KW - 1){1'b0}}, 1'b1});
  assign k_up   = k + lowbit;
  assign k_down = k - lowbit;
  assign probe  = KW'(pos) + KW'(step);

  // Entry k covers lines (k - lowbit, k]; it holds data only once the first of
  // those lines has been appended since the last clear. Older contents are stale.
  assign entry_live = KW'(line_total) > k_down;
  assign app_new    = (entry_live ? rdata : '0) + amount_ob;
  assign fits       = (sum_v + rdata_v) <= amt_v;

  assign raddr = (mode == MODE_LOCATE) ? probe[AW-1:0] : k[AW-1:0];

  lofi_ram #(
    .WIDTH(OB),
    .DEPTH(MAX_LINES + 1)
  ) u_tree (
    .clk  (clk),
    .we   (cmd.app_wr),
    .waddr(k[AW-1:0]),
    .wdata(app_new),
    .re   (cmd.mem_rd),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    stat.mode     = mode;
    stat.full_err = (KW'(line_total) >= KMax) || ((byte_v + amt_v) > OMask);
    stat.loc_err  = amt_v > byte_v;
    stat.rng_err  = amt_v >= line_v;
    stat.app_more = k_up <= KMax;
    stat.probe_ok = probe <= KW'(line_total);
    stat.loc_more = step != '0;
    stat.rng_more = k != '0;
    stat.pass2    = pass2;
    stat.out_free = !out_valid || !out_stall;
  end

  always_comb begin
    res = '0;
    case (cmd.res_kind)
      RES_FULL: begin
        res.status      = STAT_FULL;
        res.first_value = FieldW'(line_total);
      end
      RES_BAD: begin
        res.status = STAT_RANGE;
      end
      RES_APPEND: begin
        res.status      = STAT_OK;
        res.first_value = FieldW'(KW'(line_total) + {{(KW - 1){1'b0}}, 1'b1});
      end
      RES_LOCATE: begin
        res.status       = STAT_OK;
        res.first_value  = FieldW'(pos);
        res.second_value = FieldW'(amt_v - sum_v);
      end
      RES_RANGE: begin
        res.status       = STAT_OK;
        res.first_value  = FieldW'(start);
        res.second_value = FieldW'(sum - start);
      end
      RES_CLEAR: begin
        res.status = STAT_OK;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_total <= '0;
      byte_total <= '0;
      out_valid  <= 1'b0;
      pass2      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        pass2 <= 1'b0;
      end else if (cmd.rng_second) begin
        pass2 <= 1'b1;
      end
      if (cmd.clear) begin
        line_total <= '0;
        byte_total <= '0;
      end else if (cmd.res_load && cmd.res_kind == RES_APPEND) begin
        line_total <= line_total + {{(LW - 1){1'b0}}, 1'b1};
        byte_total <= byte_total + amount_ob;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode   <= in_data.mode;
      amount <= in_data.amount;
      pos    <= '0;
      step   <= StepTop;
      sum    <= '0;
      if (in_data.mode == MODE_APPEND) begin
        k <= KW'(line_total) + {{(KW - 1){1'b0}}, 1'b1};
      end else begin
        k <= KW'(in_data.amount);
      end
    end
    if (cmd.app_wr) begin
      k <= k_up;
    end
    if (cmd.loc_skip) begin
      step <= step >> 1;
    end
    if (cmd.loc_cmp) begin
      step <= step >> 1;
      if (fits) begin
        sum <= sum + rdata;
        pos <= probe[LW-1:0];
      end
    end
    if (cmd.rng_acc) begin
      sum <= sum + rdata;
      k   <= k_down;
    end
    if (cmd.rng_second) begin
      start <= sum;
      sum   <= '0;
      k     <= KW'(amount) + {{(KW - 1){1'b0}}, 1'b1};
    end
    if (cmd.res_load) begin
      out_data <= res;
    end
  end

endmodule

### design/lofi_ctrl.sv
`timescale 1ns / 1ps
module lofi_ctrl import lofi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  lofi_stat_t stat,
  output lofi_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_APP_RD   = 9'b000000100,
    S_APP_WR   = 9'b000001000,
    S_LOC_STEP = 9'b000010000,
    S_LOC_CMP  = 9'b000100000,
    S_RNG_STEP = 9'b001000000,
    S_RNG_ACC  = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cmd          = '0;
    cmd.res_kind = kind;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          MODE_APPEND: begin
            if (stat.full_err) begin
              kind_next  = RES_FULL;
              state_next = S_FINISH;
            end else begin
              state_next = S_APP_RD;
            end
          end
          MODE_LOCATE: begin
            if (stat.loc_err) begin
              kind_next  = RES_BAD;
              state_next = S_FINISH;
            end else begin
              state_next = S_LOC_STEP;
            end
          end
          MODE_RANGE: begin
            if (stat.rng_err) begin
              kind_next  = RES_BAD;
              state_next = S_FINISH;
            end else begin
              state_next = S_RNG_STEP;
            end
          end
          default: begin
            cmd.clear  = 1'b1;
            kind_next  = RES_CLEAR;
            state_next = S_FINISH;
          end
        endcase
      end
      S_APP_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_APP_WR;
      end
      S_APP_WR: begin
        cmd.app_wr = 1'b1;
        if (stat.app_more) begin
          state_next = S_APP_RD;
        end else begin
          kind_next  = RES_APPEND;
          state_next = S_FINISH;
        end
      end
      S_LOC_STEP: begin
        if (!stat.loc_more) begin
          kind_next  = RES_LOCATE;
          state_next = S_FINISH;
        end else if (stat.probe_ok) begin
          cmd.mem_rd = 1'b1;
          state_next = S_LOC_CMP;
        end else begin
          // probe lies past the last line: halve without touching the tree
          cmd.loc_skip = 1'b1;
        end
      end
      S_LOC_CMP: begin
        cmd.loc_cmp = 1'b1;
        state_next  = S_LOC_STEP;
      end
      S_RNG_STEP: begin
        if (stat.rng_more) begin
          cmd.mem_rd = 1'b1;
          state_next = S_RNG_ACC;
        end else if (!stat.pass2) begin
          cmd.rng_second = 1'b1;
        end else begin
          kind_next  = RES_RANGE;
          state_next = S_FINISH;
        end
      end
      S_RNG_ACC: begin
        cmd.rng_acc = 1'b1;
        state_next  = S_RNG_STEP;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_CLEAR;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

### design/line_offset_fenwick_index_top.sv
`timescale 1ns / 1ps
// Line offset index over a Fenwick tree of line lengths kept in one
// single-port-read RAM of MAX_LINES+1 words. One request is worked at a time;
// every tree entry touched takes an address out and registered data back, so
// the work follows the tree walk: append visits each entry on the update path
// (at most log2(MAX_LINES)+1 entries); locate visits up to one entry per level
// over log2(MAX_LINES)+1 levels, skipping probes past the last line; a range
// query visits one entry per set bit of the line index and of the index plus
// one. Errors and clear answer without a tree walk. The next request is
// taken as soon as the result is in the output register. No clearing pass is
// needed after reset or clear: stale tree words are masked by the line count.
module line_offset_fenwick_index_top import lofi_pkg::*; #(
  parameter int MAX_LINES   = MaxLinesDef,
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  req_t  in_data,
  output logic  out_valid,
  input  logic  out_stall,
  output resp_t out_data
);

  lofi_cmd_t  cmd;
  lofi_stat_t stat;

  lofi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  lofi_datapath #(
    .MAX_LINES  (MAX_LINES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

### tb/sv/tb_line_offset_fenwick_index_top.sv
`timescale 1ns / 1ps
module tb_line_offset_fenwick_index_top;
  import lofi_pkg::*;

  localparam int          LINES      = MaxLinesDef;
  localparam int unsigned BYTE_LIMIT = (1 << OffsetBitsDef) - 1;
  localparam int          WATCHDOG   = 4000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  req_t  in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  resp_t out_data;

  line_offset_fenwick_index_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  req_t  req_q[$];
  resp_t answer_q[$];
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    n_err = 0;
  int    n_req = 0;
  int    n_ans = 0;
  int    n_full = 0;
  int    n_oor = 0;
  int    peak_lines = 0;
  int    quiet_cycles = 0;

  // shadow of the index, updated as requests are accepted
  logic [23:0] tree_m [0:LINES];
  logic [10:0] line_cnt;
  logic [23:0] byte_sum;

  initial begin
    for (int i = 0; i <= LINES; i++) tree_m[i] = '0;
    line_cnt = '0;
    byte_sum = '0;
  end

  function automatic logic [23:0] prefix_len(input int unsigned cnt);
    logic [23:0] s;
    int unsigned k;
    s = '0;
    k = cnt;
    while (k > 0) begin
      s += tree_m[k];
      k -= k & (~k + 1);
    end
    return s;
  endfunction

  function automatic resp_t index_predict(input req_t r);
    resp_t a;
    int unsigned k, step, pos, probe;
    logic [25:0] acc;
    logic [23:0] lo, hi;
    a = '0;
    a.status = STAT_OK;
    case (r.mode)
      MODE_APPEND: begin
        if (line_cnt >= LINES || 32'(byte_sum) + 32'(r.amount) > BYTE_LIMIT) begin
          a.status = STAT_FULL;
          a.first_value = 24'(line_cnt);
        end else begin
          for (k = line_cnt + 1; k <= LINES; k += k & (~k + 1))
            tree_m[k] = tree_m[k] + r.amount;
          line_cnt = line_cnt + 1'b1;
          byte_sum = byte_sum + r.amount;
          a.first_value = 24'(line_cnt);
          if (int'(line_cnt) > peak_lines) peak_lines = int'(line_cnt);
        end
      end
      MODE_LOCATE: begin
        if (r.amount > byte_sum) begin
          a.status = STAT_RANGE;
        end else begin
          step = 0;
          pos = 0;
          acc = '0;
          if (line_cnt > 0) begin
            step = 1;
            while ((step << 1) <= line_cnt) step <<= 1;
          end
          // binary descent: keep the furthest node whose prefix still fits
          while (step > 0) begin
            probe = pos + step;
            if (probe <= line_cnt) begin
              if (acc + tree_m[probe] <= r.amount) begin
                acc += tree_m[probe];
                pos = probe;
              end
            end
            step >>= 1;
          end
          a.first_value  = 24'(pos);
          a.second_value = r.amount - acc[23:0];
        end
      end
      MODE_RANGE: begin
        if (r.amount >= line_cnt) begin
          a.status = STAT_RANGE;
        end else begin
          lo = prefix_len(32'(r.amount));
          hi = prefix_len(32'(r.amount) + 1);
          a.first_value  = lo;
          a.second_value = hi - lo;
        end
      end
      MODE_CLEAR: begin
        for (k = 0; k <= LINES; k++) tree_m[k] = '0;
        line_cnt = '0;
        byte_sum = '0;
      end
      default: ;
    endcase
    return a;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        answer_q.push_back(index_predict(in_data));
        n_req++;
      end
      if (!in_valid || in_fire) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // answer monitor
  always @(posedge clk) begin
    resp_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_fire) begin
        n_ans++;
        if (answer_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected answer %p", $time, out_data);
        end else begin
          exp_r = answer_q.pop_front();
          if (exp_r.status == STAT_FULL) n_full++;
          if (exp_r.status == STAT_RANGE) n_oor++;
          if (out_data.status !== exp_r.status) begin
            n_err++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, out_data.status);
          end
          if (out_data.first_value !== exp_r.first_value) begin
            n_err++;
            $display("%0t: first_value expected %0h actual %0h", $time,
                     exp_r.first_value, out_data.first_value);
          end
          if (out_data.second_value !== exp_r.second_value) begin
            n_err++;
            $display("%0t: second_value expected %0h actual %0h", $time,
                     exp_r.second_value, out_data.second_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // rough line/byte counts so generated offsets and indexes land in range
  int unsigned gen_lines = 0;
  int unsigned gen_bytes = 0;

  task automatic push_req(input mode_t m, input logic [23:0] amt);
    req_t r;
    r.mode = m;
    r.amount = amt;
    req_q.push_back(r);
    case (m)
      MODE_APPEND: begin
        if (gen_lines < LINES && gen_bytes + amt <= BYTE_LIMIT) begin
          gen_lines++;
          gen_bytes += amt;
        end
      end
      MODE_CLEAR: begin
        gen_lines = 0;
        gen_bytes = 0;
      end
      default: ;
    endcase
  endtask

  task automatic random_mix(input int n, input int app_pct, input int clr_pct);
    int roll, pick;
    logic [23:0] amt;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < app_pct) begin
        if (pick < 55) amt = 24'($urandom_range(0, 255));
        else if (pick < 82) amt = 24'($urandom_range(0, 65535));
        else if (pick < 94) amt = '0;
        else amt = 24'($urandom);
        push_req(MODE_APPEND, amt);
      end else if (roll < 100 - clr_pct) begin
        if (pick < 55) begin
          if (pick < 44) amt = 24'($urandom_range(0, gen_bytes));
          else if (pick < 50) amt = 24'(gen_bytes);
          else amt = 24'($urandom);
          push_req(MODE_LOCATE, amt);
        end else begin
          if (pick < 92 && gen_lines > 0) amt = 24'($urandom_range(0, gen_lines - 1));
          else if (pick < 96) amt = 24'(gen_lines);
          else amt = 24'($urandom);
          push_req(MODE_RANGE, amt);
        end
      end else begin
        push_req(MODE_CLEAR, 24'($urandom));
      end
    end
  endtask

  initial begin
    int ph;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      if (ph == 0) begin
        // empty store: locate at zero, past end, range on nothing
        push_req(MODE_LOCATE, 24'd0);
        push_req(MODE_LOCATE, 24'd7);
        push_req(MODE_RANGE, 24'd0);
        push_req(MODE_APPEND, 24'd0);
        push_req(MODE_APPEND, 24'd5);
        push_req(MODE_APPEND, 24'd3);
        push_req(MODE_LOCATE, 24'd0);
        push_req(MODE_LOCATE, 24'd5);
        push_req(MODE_LOCATE, 24'd8);
        push_req(MODE_LOCATE, 24'd9);
        push_req(MODE_RANGE, 24'd0);
        push_req(MODE_RANGE, 24'd2);
        push_req(MODE_RANGE, 24'd3);
        // fill the byte total exactly, then overflow it
        push_req(MODE_APPEND, 24'hFFFFF7);
        push_req(MODE_APPEND, 24'd1);
        push_req(MODE_APPEND, 24'd0);
        push_req(MODE_LOCATE, 24'hFFFFFF);
        push_req(MODE_LOCATE, 24'hAAAAAA);
        push_req(MODE_LOCATE, 24'h555555);
        push_req(MODE_RANGE, 24'd3);
        push_req(MODE_CLEAR, 24'hFFFFFF);
        push_req(MODE_RANGE, 24'd0);
        push_req(MODE_LOCATE, 24'd0);
        // fill every line slot, then hit the line-count limit
        for (int i = 0; i < LINES; i++)
          push_req(MODE_APPEND, ($urandom_range(0, 15) == 0) ?
                   24'($urandom_range(0, 4095)) : 24'($urandom_range(0, 63)));
        for (int i = 0; i < 6; i++) push_req(MODE_APPEND, 24'($urandom_range(0, 3)));
        random_mix(40, 5, 0);
        random_mix(60, 40, 4);
      end else begin
        random_mix(145, 40, 4);
      end
      while (req_q.size() != 0 || answer_q.size() != 0 || in_valid) @(posedge clk);
    end
    repeat (40) @(posedge clk);
    $display("ran %0d requests over four handshake-pressure phases, up to %0d lines",
             n_req, peak_lines);
    $display("answers seen %0d: %0d store full, %0d out of range, %0d mismatches",
             n_ans, n_full, n_oor, n_err);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
